// ===== hdl/dsi_pkg.sv =====
// shared types and constants for the decimal string to integer converter
// no dependencies; used by dsi_step, decimal_string_to_int_saturating_core and the testbench
package dsi_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int CHARS_W            = 16;
  localparam int VALUE_W            = 64;
  localparam int TYPE_W             = 3;
  localparam int ADDR_W             = 3;
  localparam int DATA_W             = 32;

  // register map
  localparam logic [ADDR_W-1:0] REG_TARGET_TYPE = 3'd0;

  // clamp target codes
  localparam logic [TYPE_W-1:0] TT_U16 = 3'd0;
  localparam logic [TYPE_W-1:0] TT_U32 = 3'd1;
  localparam logic [TYPE_W-1:0] TT_U64 = 3'd2;
  localparam logic [TYPE_W-1:0] TT_I16 = 3'd3;
  localparam logic [TYPE_W-1:0] TT_I32 = 3'd4;
  localparam logic [TYPE_W-1:0] TT_I64 = 3'd5;

  localparam logic [TYPE_W-1:0] TARGET_TYPE_RESET = TT_U64;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // magnitude of the most negative value for each signed target
  localparam logic [VALUE_W-1:0] NEGABS_I16 = 64'd32768;
  localparam logic [VALUE_W-1:0] NEGABS_I32 = 64'd2147483648;
  localparam logic [VALUE_W-1:0] NEGABS_I64 = 64'h8000_0000_0000_0000;

  localparam logic [VALUE_W-1:0] MAX_U16 = 64'h0000_0000_0000_FFFF;
  localparam logic [VALUE_W-1:0] MAX_U32 = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [3:0] {
    PH_SPACE  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DRAIN  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    logic               parsed_ok;
    logic [CHARS_W-1:0] chars_used;
  } result_t;

endpackage

// ===== hdl/dsi_step.sv =====
// parser state and per-character update: whitespace, sign, digit accumulation, clamp
// depends on dsi_pkg
module dsi_step #(
  parameter int COUNT_BITS = dsi_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  char_in,
  input  logic [dsi_pkg::TYPE_W-1:0]  target_type,
  output logic                        res_valid,
  output dsi_pkg::result_t            res
);

  dsi_pkg::phase_t              phase, phase_next;
  logic                         negative_flag, negative_flag_next;
  logic [dsi_pkg::VALUE_W-1:0]  magnitude, magnitude_next;
  logic [COUNT_BITS-1:0]        char_count, char_count_next;

  logic                         is_digit, is_space;
  logic [3:0]                   digit;
  logic [dsi_pkg::VALUE_W+3:0]  mag_x10;
  logic [COUNT_BITS-1:0]        count_inc;
  logic [dsi_pkg::VALUE_W-1:0]  clamped;
  logic [dsi_pkg::CHARS_W-1:0]  count_out;
  logic [dsi_pkg::VALUE_W-1:0]  negabs;
  logic                         is_signed;

  assign is_digit = (char_in inside {[dsi_pkg::CH_ZERO:dsi_pkg::CH_NINE]});
  assign is_space = (char_in inside {[dsi_pkg::CH_TAB:dsi_pkg::CH_CR], dsi_pkg::CH_SPACE});
  assign digit    = 4'(char_in - dsi_pkg::CH_ZERO);

  // m*10 + d as two shifts and adds; any carry above bit 63 means saturation
  assign mag_x10 = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1)
                   + {{dsi_pkg::VALUE_W{1'b0}}, digit};

  assign count_inc = (char_count == {COUNT_BITS{1'b1}}) ? char_count
                                                         : char_count + COUNT_BITS'(1);

  generate
    if (COUNT_BITS > dsi_pkg::CHARS_W) begin : g_count_sat
      assign count_out = (|char_count[COUNT_BITS-1:dsi_pkg::CHARS_W])
                         ? {dsi_pkg::CHARS_W{1'b1}}
                         : char_count[dsi_pkg::CHARS_W-1:0];
    end else begin : g_count_ext
      assign count_out = dsi_pkg::CHARS_W'(char_count);
    end
  endgenerate

  // clamp the stored magnitude to the selected target
  always_comb begin
    negabs    = dsi_pkg::NEGABS_I64;
    is_signed = 1'b0;
    clamped   = magnitude;
    case (target_type)
      dsi_pkg::TT_U16: clamped = (magnitude > dsi_pkg::MAX_U16) ? dsi_pkg::MAX_U16 : magnitude;
      dsi_pkg::TT_U32: clamped = (magnitude > dsi_pkg::MAX_U32) ? dsi_pkg::MAX_U32 : magnitude;
      dsi_pkg::TT_I16: begin
        negabs    = dsi_pkg::NEGABS_I16;
        is_signed = 1'b1;
      end
      dsi_pkg::TT_I32: begin
        negabs    = dsi_pkg::NEGABS_I32;
        is_signed = 1'b1;
      end
      dsi_pkg::TT_I64: begin
        negabs    = dsi_pkg::NEGABS_I64;
        is_signed = 1'b1;
      end
      default: clamped = magnitude;
    endcase
    if (is_signed) begin
      if (!negative_flag) begin
        clamped = (magnitude >= negabs) ? negabs - 64'd1 : magnitude;
      end else if (magnitude > negabs) begin
        clamped = '0 - negabs;
      end else begin
        clamped = '0 - magnitude;
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    negative_flag_next = negative_flag;
    magnitude_next     = magnitude;
    char_count_next    = char_count;
    res_valid          = 1'b0;
    res                = '0;
    if (accept) begin
      if (phase == dsi_pkg::PH_DRAIN) begin
        if (char_in == dsi_pkg::CH_NUL) begin
          phase_next = dsi_pkg::PH_SPACE;
        end
      end else if (is_digit) begin
        if (phase != dsi_pkg::PH_DIGITS) begin
          magnitude_next = {{(dsi_pkg::VALUE_W-4){1'b0}}, digit};
        end else if (|mag_x10[dsi_pkg::VALUE_W+3:dsi_pkg::VALUE_W]) begin
          magnitude_next = {dsi_pkg::VALUE_W{1'b1}};
        end else begin
          magnitude_next = mag_x10[dsi_pkg::VALUE_W-1:0];
        end
        phase_next      = dsi_pkg::PH_DIGITS;
        char_count_next = count_inc;
      end else if (phase == dsi_pkg::PH_SPACE && is_space) begin
        char_count_next = count_inc;
      end else if (phase == dsi_pkg::PH_SPACE &&
                   (char_in == dsi_pkg::CH_PLUS || char_in == dsi_pkg::CH_MINUS)) begin
        negative_flag_next = (char_in == dsi_pkg::CH_MINUS);
        phase_next         = dsi_pkg::PH_SIGN;
        char_count_next    = count_inc;
      end else begin
        // stop character ends the number
        res_valid = 1'b1;
        if (phase == dsi_pkg::PH_DIGITS) begin
          res.value_bits = clamped;
          res.parsed_ok  = 1'b1;
          res.chars_used = count_out;
        end
        negative_flag_next = 1'b0;
        magnitude_next     = '0;
        char_count_next    = '0;
        phase_next = (char_in == dsi_pkg::CH_NUL) ? dsi_pkg::PH_SPACE : dsi_pkg::PH_DRAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dsi_pkg::PH_SPACE;
      negative_flag <= 1'b0;
      magnitude     <= '0;
      char_count    <= '0;
    end else begin
      phase         <= phase_next;
      negative_flag <= negative_flag_next;
      magnitude     <= magnitude_next;
      char_count    <= char_count_next;
    end
  end

endmodule

// ===== hdl/decimal_string_to_int_saturating_core.sv =====
// top level: apb register, character input, two-entry result buffer
// depends on dsi_pkg and dsi_step
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   input   | in        | in_valid / in_stall    | char_in
//   output  | out       | out_valid / out_stall  | value_bits, parsed_ok, chars_used
//   config  | in/out    | psel, penable, pready  | paddr, pwdata, prdata (target_type)
//
// one character per cycle while in_stall is low; the result for an accepted stop
// character is formed combinationally and registered in a result entry
// a skid entry behind the result register keeps input open while one result waits
// in_stall rises only when both result entries are full
// reset is synchronous; target_type returns to u64
module decimal_string_to_int_saturating_core #(
  parameter int COUNT_BITS = dsi_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  char_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dsi_pkg::VALUE_W-1:0] value_bits,
  output logic                        parsed_ok,
  output logic [dsi_pkg::CHARS_W-1:0] chars_used,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsi_pkg::ADDR_W-1:0]  paddr,
  input  logic [dsi_pkg::DATA_W-1:0]  pwdata,
  output logic [dsi_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [dsi_pkg::TYPE_W-1:0] target_type;
  logic                       accept;
  logic                       res_valid;
  dsi_pkg::result_t           res;
  dsi_pkg::result_t           out_res, skid_res;
  logic                       skid_valid;
  logic                       take;

  assign pready = 1'b1;
  assign prdata = (paddr == dsi_pkg::REG_TARGET_TYPE)
                  ? dsi_pkg::DATA_W'(target_type) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_type <= dsi_pkg::TARGET_TYPE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == dsi_pkg::REG_TARGET_TYPE) begin
      target_type <= pwdata[dsi_pkg::TYPE_W-1:0];
    end
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  dsi_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_in     (char_in),
    .target_type (target_type),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !take) begin
      // result register held; a new result parks in the skid entry
      if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !take) begin
      if (res_valid) begin
        skid_res <= res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (res_valid) begin
      out_res <= res;
    end
  end

  assign value_bits = out_res.value_bits;
  assign parsed_ok  = out_res.parsed_ok;
  assign chars_used = out_res.chars_used;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while result register empty");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !parsed_ok) |-> (value_bits == '0 && chars_used == '0))
    else $error("failed parse carries nonzero value or count");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (out_valid && !skid_valid))
    else $error("skid entry did not advance after transaction");

  a_ok_has_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && parsed_ok) |-> (chars_used != '0))
    else $error("successful parse reports zero characters");
`endif

endmodule

// ===== tb/tb_decimal_string_to_int_saturating_core.sv =====
// testbench for decimal_string_to_int_saturating_core: streams strings, checks each
// number result against a behavioral parser kept in step with the accepted characters
// depends on dsi_pkg and the core rtl
`timescale 1ns / 1ps

module tb_decimal_string_to_int_saturating_core;

  localparam int          HOLD_CYCLES = 80;
  localparam int          DIR_ROWS    = 25;
  localparam logic [31:0] COUNT_MAX   = (32'd1 << dsi_pkg::COUNT_BITS_DEFAULT) - 32'd1;
  localparam logic [63:0] CLAMP_BOUNDS [9] = '{
    64'd32767, 64'd32768, 64'd65535, 64'd2147483647, 64'd2147483648,
    64'd4294967295, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  typedef struct {
    logic [7:0]       ch;
    bit               typed;
    dsi_pkg::result_t want;
  } dir_row_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [7:0]                   char_in;
  logic                         out_valid;
  logic                         out_stall;
  logic [dsi_pkg::VALUE_W-1:0]  value_bits;
  logic                         parsed_ok;
  logic [dsi_pkg::CHARS_W-1:0]  chars_used;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dsi_pkg::ADDR_W-1:0]   paddr;
  logic [dsi_pkg::DATA_W-1:0]   pwdata;
  logic [dsi_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // parser state mirrored from the accepted characters
  dsi_pkg::phase_t              prs_phase;
  logic                         prs_negative;
  logic [63:0]                  prs_magnitude;
  logic [31:0]                  prs_count;
  logic [dsi_pkg::TYPE_W-1:0]   prs_target;

  dsi_pkg::result_t             result_q [$];
  logic [7:0]                   str_chars [$];
  dir_row_t                     dir_table [DIR_ROWS];

  int                           error_count;
  int                           chars_sent;
  int                           strings_sent;
  int                           results_checked;
  bit                           sender_gaps;
  bit                           receiver_quiet;
  bit                           hold_request;
  logic [7:0]                   targets_seen;

  decimal_string_to_int_saturating_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_bits (value_bits),
    .parsed_ok  (parsed_ok),
    .chars_used (chars_used),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return (c >= dsi_pkg::CH_TAB && c <= dsi_pkg::CH_CR) || c == dsi_pkg::CH_SPACE;
  endfunction

  function automatic logic [63:0] clamp_to_target();
    logic [63:0] negabs;
    negabs = '0;
    case (prs_target)
      dsi_pkg::TT_U16:
        return (prs_magnitude > dsi_pkg::MAX_U16) ? dsi_pkg::MAX_U16 : prs_magnitude;
      dsi_pkg::TT_U32:
        return (prs_magnitude > dsi_pkg::MAX_U32) ? dsi_pkg::MAX_U32 : prs_magnitude;
      dsi_pkg::TT_I16: negabs = dsi_pkg::NEGABS_I16;
      dsi_pkg::TT_I32: negabs = dsi_pkg::NEGABS_I32;
      dsi_pkg::TT_I64: negabs = dsi_pkg::NEGABS_I64;
      default: return prs_magnitude;
    endcase
    if (!prs_negative)
      return (prs_magnitude > negabs - 64'd1) ? negabs - 64'd1 : prs_magnitude;
    if (prs_magnitude > negabs)
      return 64'd0 - negabs;
    return 64'd0 - prs_magnitude;
  endfunction

  task automatic bump_count();
    if (prs_count < COUNT_MAX)
      prs_count = prs_count + 32'd1;
  endtask

  // advance the parser by one character; flags a number result when it ends
  task automatic parse_char(input logic [7:0] c, output bit has_res,
                            output dsi_pkg::result_t res);
    logic [63:0] d;
    has_res = 1'b0;
    res     = '0;
    d       = 64'(c - dsi_pkg::CH_ZERO);
    if (prs_phase == dsi_pkg::PH_DRAIN) begin
      if (c == dsi_pkg::CH_NUL)
        prs_phase = dsi_pkg::PH_SPACE;
    end else if (c >= dsi_pkg::CH_ZERO && c <= dsi_pkg::CH_NINE) begin
      if (prs_phase != dsi_pkg::PH_DIGITS) begin
        prs_magnitude = d;
        prs_phase     = dsi_pkg::PH_DIGITS;
      end else if (prs_magnitude > 64'hFFFF_FFFF_FFFF_FFFF / 64'd10 ||
                   prs_magnitude * 64'd10 > 64'hFFFF_FFFF_FFFF_FFFF - d) begin
        prs_magnitude = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
        prs_magnitude = prs_magnitude * 64'd10 + d;
      end
      bump_count();
    end else if (prs_phase == dsi_pkg::PH_SPACE && is_blank(c)) begin
      bump_count();
    end else if (prs_phase == dsi_pkg::PH_SPACE &&
                 (c == dsi_pkg::CH_PLUS || c == dsi_pkg::CH_MINUS)) begin
      prs_negative = (c == dsi_pkg::CH_MINUS);
      prs_phase    = dsi_pkg::PH_SIGN;
      bump_count();
    end else begin
      // stop character closes the number
      has_res = 1'b1;
      if (prs_phase == dsi_pkg::PH_DIGITS) begin
        res.value_bits = clamp_to_target();
        res.parsed_ok  = 1'b1;
        res.chars_used = (prs_count > 32'd65535) ? 16'hFFFF : prs_count[15:0];
      end
      prs_negative  = 1'b0;
      prs_magnitude = '0;
      prs_count     = '0;
      prs_phase     = (c == dsi_pkg::CH_NUL) ? dsi_pkg::PH_SPACE : dsi_pkg::PH_DRAIN;
    end
  endtask

  task automatic send_char(input logic [7:0] c, input bit typed,
                           input dsi_pkg::result_t want);
    bit               taken;
    bit               has_res;
    dsi_pkg::result_t pred;
    while (sender_gaps && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    parse_char(c, has_res, pred);
    if (has_res)
      result_q.push_back(typed ? want : pred);
    chars_sent++;
  endtask

  task automatic send_string();
    dsi_pkg::result_t none;
    none = '0;
    foreach (str_chars[k])
      send_char(str_chars[k], 1'b0, none);
    strings_sent++;
  endtask

  // block is idle once every result is back and the last character has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [dsi_pkg::ADDR_W-1:0] addr,
                           input logic [dsi_pkg::DATA_W-1:0] data);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [dsi_pkg::ADDR_W-1:0] addr,
                          output logic [dsi_pkg::DATA_W-1:0] data);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy  = pready;
      data = prdata;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_target(input logic [dsi_pkg::TYPE_W-1:0] tt);
    logic [dsi_pkg::DATA_W-1:0] rd;
    apb_read(dsi_pkg::REG_TARGET_TYPE, rd);
    if (rd !== dsi_pkg::DATA_W'(tt)) begin
      $error("target_type readback mismatch: expected %0d, actual %0d", tt, rd);
      error_count++;
    end
  endtask

  // upper data bits are don't-care for a 3-bit register
  task automatic set_target(input logic [dsi_pkg::TYPE_W-1:0] tt);
    apb_write(dsi_pkg::REG_TARGET_TYPE, {29'($urandom), tt});
    prs_target = tt;
    targets_seen[tt] = 1'b1;
    check_target(tt);
  endtask

  task automatic push_decimal(input logic [63:0] v);
    logic [7:0] digs [$];
    do begin
      digs.push_front(dsi_pkg::CH_ZERO + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digs[k])
      str_chars.push_back(digs[k]);
  endtask

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 5) == 5) ? dsi_pkg::CH_SPACE
                                       : dsi_pkg::CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] rand_stop();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c >= dsi_pkg::CH_ZERO && c <= dsi_pkg::CH_NINE);
    return c;
  endfunction

  // NUL right away or a stop character, some trailing text, then NUL
  task automatic push_ending();
    if ($urandom_range(0, 1)) begin
      str_chars.push_back(dsi_pkg::CH_NUL);
    end else begin
      str_chars.push_back(rand_stop());
      repeat ($urandom_range(0, 3)) str_chars.push_back(8'($urandom_range(1, 255)));
      str_chars.push_back(dsi_pkg::CH_NUL);
    end
  endtask

  task automatic build_string();
    str_chars.delete();
    if ($urandom_range(0, 99) < 80) begin
      repeat ($urandom_range(0, 3)) str_chars.push_back(rand_blank());
      case ($urandom_range(0, 2))
        1: str_chars.push_back(dsi_pkg::CH_PLUS);
        2: str_chars.push_back(dsi_pkg::CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 22)) str_chars.push_back(dsi_pkg::CH_ZERO);
      case ($urandom_range(0, 4))
        0: push_decimal(64'($urandom_range(0, 999)));
        1: push_decimal(CLAMP_BOUNDS[$urandom_range(0, 8)] + 64'($urandom_range(0, 4))
                        - 64'd2);
        2: begin
          // one digit past (2^64-1)/10 lands on either side of saturation
          push_decimal(64'd1844674407370955161);
          str_chars.push_back(dsi_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        3: push_decimal({$urandom, $urandom} >> $urandom_range(0, 63));
        default: repeat ($urandom_range(20, 30))
          str_chars.push_back(dsi_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      endcase
      push_ending();
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          str_chars.push_back($urandom_range(0, 1) ? dsi_pkg::CH_PLUS : dsi_pkg::CH_MINUS);
          push_ending();
        end
        1: begin
          str_chars.push_back(dsi_pkg::CH_MINUS);
          str_chars.push_back(dsi_pkg::CH_PLUS);
          str_chars.push_back(dsi_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          str_chars.push_back(dsi_pkg::CH_NUL);
        end
        2: begin
          repeat ($urandom_range(1, 4)) str_chars.push_back(rand_blank());
          push_ending();
        end
        default: begin
          repeat ($urandom_range(1, 8)) str_chars.push_back(8'($urandom));
          str_chars.push_back(dsi_pkg::CH_NUL);
        end
      endcase
    end
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (rst || receiver_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 20);
      end
    end
  end

  // a transaction is taken at the next rising edge, so compare on the falling edge
  always @(negedge clk) begin
    dsi_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result with no expectation: value_bits %h parsed_ok %0d chars_used %0d",
               value_bits, parsed_ok, chars_used);
        error_count++;
      end else begin
        want = result_q.pop_front();
        results_checked++;
        if (value_bits !== want.value_bits) begin
          $error("value_bits mismatch: expected %h, actual %h", want.value_bits, value_bits);
          error_count++;
        end
        if (parsed_ok !== want.parsed_ok) begin
          $error("parsed_ok mismatch: expected %0d, actual %0d", want.parsed_ok, parsed_ok);
          error_count++;
        end
        if (chars_used !== want.chars_used) begin
          $error("chars_used mismatch: expected %0d, actual %0d", want.chars_used, chars_used);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int phase_chars;
    int p;

    rst      = 1'b1;
    in_valid = 1'b0;
    char_in  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;

    error_count     = 0;
    chars_sent      = 0;
    strings_sent    = 0;
    results_checked = 0;
    sender_gaps     = 1'b1;
    receiver_quiet  = 1'b0;
    hold_request    = 1'b0;
    targets_seen    = '0;

    prs_phase     = dsi_pkg::PH_SPACE;
    prs_negative  = 1'b0;
    prs_magnitude = '0;
    prs_count     = '0;
    prs_target    = dsi_pkg::TARGET_TYPE_RESET;

    // negative zero, non-ascii stop, repeated sign, cr prefix, bare nul,
    // sign ignored by u64, leading zeros
    dir_table = '{
      '{dsi_pkg::CH_SPACE,          1'b0, '0},
      '{dsi_pkg::CH_MINUS,          1'b0, '0},
      '{dsi_pkg::CH_ZERO,           1'b0, '0},
      '{dsi_pkg::CH_NUL,            1'b1, '{64'd0, 1'b1, 16'd3}},
      '{8'hFF,                      1'b1, '{64'd0, 1'b0, 16'd0}},
      '{dsi_pkg::CH_NUL,            1'b0, '0},
      '{dsi_pkg::CH_TAB,            1'b0, '0},
      '{dsi_pkg::CH_PLUS,           1'b0, '0},
      '{dsi_pkg::CH_PLUS,           1'b1, '{64'd0, 1'b0, 16'd0}},
      '{8'h61,                      1'b0, '0},
      '{dsi_pkg::CH_NUL,            1'b0, '0},
      '{dsi_pkg::CH_CR,             1'b0, '0},
      '{dsi_pkg::CH_NINE,           1'b0, '0},
      '{dsi_pkg::CH_ZERO + 8'd7,    1'b0, '0},
      '{dsi_pkg::CH_NINE + 8'd1,    1'b1, '{64'd97, 1'b1, 16'd3}},
      '{dsi_pkg::CH_NUL,            1'b0, '0},
      '{dsi_pkg::CH_NUL,            1'b1, '{64'd0, 1'b0, 16'd0}},
      '{dsi_pkg::CH_MINUS,          1'b0, '0},
      '{dsi_pkg::CH_ZERO + 8'd5,    1'b0, '0},
      '{dsi_pkg::CH_NUL,            1'b1, '{64'd5, 1'b1, 16'd2}},
      '{dsi_pkg::CH_ZERO,           1'b0, '0},
      '{dsi_pkg::CH_ZERO,           1'b0, '0},
      '{dsi_pkg::CH_ZERO + 8'd7,    1'b0, '0},
      '{dsi_pkg::CH_ZERO - 8'd1,    1'b1, '{64'd7, 1'b1, 16'd3}},
      '{dsi_pkg::CH_NUL,            1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_target(dsi_pkg::TARGET_TYPE_RESET);
    targets_seen[dsi_pkg::TARGET_TYPE_RESET] = 1'b1;
    for (int i = 0; i < DIR_ROWS; i++)
      send_char(dir_table[i].ch, dir_table[i].typed, dir_table[i].want);
    wait_idle();

    // random strings under every target setting, one phase without idling
    for (p = 0; p < 10; p++) begin
      set_target((p < 8) ? dsi_pkg::TYPE_W'(p) : dsi_pkg::TYPE_W'($urandom_range(0, 7)));
      sender_gaps    = (p != 3);
      receiver_quiet = (p == 3);
      phase_chars    = chars_sent;
      while (chars_sent - phase_chars < 70) begin
        build_string();
        send_string();
      end
      wait_idle();
    end

    // long hold-off on the result side while short numbers keep coming
    set_target(dsi_pkg::TT_I16);
    sender_gaps    = 1'b0;
    receiver_quiet = 1'b0;
    hold_request   = 1'b1;
    repeat (30) begin
      str_chars.delete();
      str_chars.push_back(dsi_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      str_chars.push_back(dsi_pkg::CH_NUL);
      send_string();
    end
    sender_gaps = 1'b1;
    wait_idle();
    repeat (8) @(posedge clk);

    $display("summary: %0d characters in %0d strings, %0d results checked",
             chars_sent, strings_sent, results_checked);
    $display("summary: clamp targets exercised mask %b, saturation bounds and hold-off included",
             targets_seen);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
